// ===== hdl/pidsd_pkg.sv =====
// Shared types, register codes, reset values and saturation helper for the PID step block.
package pidsd_pkg;

    localparam int unsigned SIG_W = 32;
    localparam int unsigned MAG_W = 31;
    localparam int unsigned GAIN_W = 16;
    localparam int unsigned DER_W = 33;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic signed [SIG_W-1:0] SIG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SIG_W-1:0] SIG_MIN = 32'sh8000_0000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_ZONE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_THR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DER_THR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DRIVE = 3'd7;

    typedef struct packed {
        logic signed [SIG_W-1:0] target;
        logic signed [SIG_W-1:0] measured;
        logic [MAG_W-1:0]        max_speed;
    } in_word_t;

    typedef struct packed {
        logic signed [SIG_W-1:0] speed;
        logic                    active;
    } out_word_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [MAG_W-1:0]  integral_zone;
        logic [MAG_W-1:0]  integral_limit;
        logic [MAG_W-1:0]  error_threshold;
        logic [MAG_W-1:0]  derivative_threshold;
        logic [MAG_W-1:0]  min_drive;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        kp:                   16'd11520,
        ki:                   16'd0,
        kd:                   16'd38400,
        integral_zone:        31'd655360,
        integral_limit:       31'h7FFF_FFFF,
        error_threshold:      31'd6554,
        derivative_threshold: 31'd7,
        min_drive:            31'd131072
    };

    // One classified step handed from the front to the back
    typedef struct packed {
        logic                    active;
        logic signed [SIG_W-1:0] err;
        logic signed [SIG_W-1:0] integral;
        logic signed [DER_W-1:0] deriv;
        logic [MAG_W-1:0]        max_speed;
    } work_t;

    // Saturate a 33-bit signed value to the signed 32-bit range
    function automatic logic signed [SIG_W-1:0] sat33(input logic signed [SIG_W:0] v);
        logic signed [SIG_W-1:0] r;
        if (v[SIG_W] != v[SIG_W-1])
        begin
            r = v[SIG_W] ? SIG_MIN : SIG_MAX;
        end
        else
        begin
            r = v[SIG_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/pid_step_with_settle_detect.sv =====
// Top level of one PID channel with integral clamp and settle detection.
//
//   Channel   Direction  Handshake             Word
//   in        input      in_valid / in_stall   in_data  (target, measured, max_speed)
//   out       output     out_valid / out_stall out_data (speed, active)
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// Throughput is one word per cycle while the queue is not full and out is not stalled.
// The front end settles the loop state for a word in the cycle it is accepted; the
// back end registers products, the scaled saturated sum and the clamped output word.
// Reset clears the loop state, the queue and all valid flags, and loads the
// gain and threshold registers with their defaults.
// in_stall rises only while the QUEUE_DEPTH-entry queue is full; an output
// stall backs up the back end first, then the queue.
module pid_step_with_settle_detect #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pidsd_pkg::in_word_t            in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pidsd_pkg::out_word_t           out_data,
    input  logic                           cfg_we,
    input  logic [pidsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pidsd_pkg::MAG_W-1:0]    cfg_data
);
    import pidsd_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_full, q_empty;
    logic  push, pop;
    work_t push_data, pop_data;

    // Configuration writes land here; gains take the low 16 bits of the word
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KP:        cfg_next.kp = cfg_data[GAIN_W-1:0];
                CFG_KI:        cfg_next.ki = cfg_data[GAIN_W-1:0];
                CFG_KD:        cfg_next.kd = cfg_data[GAIN_W-1:0];
                CFG_INT_ZONE:  cfg_next.integral_zone = cfg_data;
                CFG_INT_LIMIT: cfg_next.integral_limit = cfg_data;
                CFG_ERR_THR:   cfg_next.error_threshold = cfg_data;
                CFG_DER_THR:   cfg_next.derivative_threshold = cfg_data;
                CFG_MIN_DRIVE: cfg_next.min_drive = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify each word and advance the loop state
    pidsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Queue: decouple the state loop from output backpressure
    pidsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // Back: weight, scale and clamp into the drive word
    pidsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/pidsd_front.sv =====
// Front end: error, settle decision, integral and derivative state update per accepted word.
module pidsd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pidsd_pkg::in_word_t in_data,
    input  pidsd_pkg::cfg_t    cfg,
    input  logic               q_full,
    output logic               push,
    output pidsd_pkg::work_t   push_data
);
    import pidsd_pkg::*;

    logic signed [SIG_W-1:0] integral_reg, integral_next;
    logic signed [DER_W-1:0] deriv_reg, deriv_next;
    logic signed [SIG_W-1:0] prev_err_reg, prev_err_next;

    logic signed [SIG_W:0]   err_wide;
    logic signed [SIG_W-1:0] err;
    logic [SIG_W-1:0]        abs_err;
    logic [DER_W-1:0]        abs_der;
    logic                    active;
    logic signed [SIG_W-1:0] int_sat;
    logic signed [SIG_W:0]   int_pre;
    logic signed [SIG_W:0]   int_lim;
    logic signed [SIG_W-1:0] int_new;
    logic signed [DER_W-1:0] deriv_new;

    assign in_stall = q_full;
    assign push = in_valid && !q_full;

    always_comb
    begin
        err_wide = {in_data.target[SIG_W-1], in_data.target}
                 - {in_data.measured[SIG_W-1], in_data.measured};
        err = sat33(err_wide);
        abs_err = err[SIG_W-1] ? (~err + 1'b1) : err;
        abs_der = deriv_reg[DER_W-1] ? (~deriv_reg + 1'b1) : deriv_reg;
        active = (abs_err > {1'b0, cfg.error_threshold})
              || (abs_der > {2'b00, cfg.derivative_threshold});

        // Accumulate inside the zone, drop the sum outside it, then clamp
        int_sat = sat33({integral_reg[SIG_W-1], integral_reg} + {err[SIG_W-1], err});
        if (abs_err < {1'b0, cfg.integral_zone})
        begin
            int_pre = {int_sat[SIG_W-1], int_sat};
        end
        else
        begin
            int_pre = '0;
        end
        int_lim = {2'b00, cfg.integral_limit};
        priority if (int_pre > int_lim)
        begin
            int_new = int_lim[SIG_W-1:0];
        end
        else if (int_pre < -int_lim)
        begin
            int_new = SIG_W'(-int_lim);
        end
        else
        begin
            int_new = int_pre[SIG_W-1:0];
        end

        deriv_new = {err[SIG_W-1], err} - {prev_err_reg[SIG_W-1], prev_err_reg};

        integral_next = integral_reg;
        deriv_next = deriv_reg;
        prev_err_next = prev_err_reg;
        if (push)
        begin
            prev_err_next = err;
            integral_next = active ? int_new : '0;
            deriv_next = active ? deriv_new : '0;
        end

        push_data.active = active;
        push_data.err = err;
        push_data.integral = int_new;
        push_data.deriv = deriv_new;
        push_data.max_speed = in_data.max_speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            deriv_reg <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            integral_reg <= integral_next;
            deriv_reg <= deriv_next;
            prev_err_reg <= prev_err_next;
        end
    end

endmodule

// ===== hdl/pidsd_queue.sv =====
// Short FIFO of classified steps between the front and the back.
module pidsd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pidsd_pkg::work_t push_data,
    output logic             full,
    input  logic             pop,
    output pidsd_pkg::work_t pop_data,
    output logic             empty
);
    import pidsd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    work_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/pidsd_back.sv =====
// Back end: gain products, scaling and saturation, speed clamp and minimum drive.
module pidsd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pidsd_pkg::cfg_t      cfg,
    input  logic                 q_empty,
    input  pidsd_pkg::work_t     pop_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pidsd_pkg::out_word_t out_data
);
    import pidsd_pkg::*;

    localparam int unsigned PE_W = GAIN_W + 1 + SIG_W;
    localparam int unsigned PD_W = GAIN_W + 1 + DER_W;
    localparam int unsigned ACC_W = PD_W + 1;
    localparam int unsigned SH_W = ACC_W - 8;

    // Stage 1: products
    logic                    s1_valid_reg, s1_valid_next;
    logic signed [PE_W-1:0]  s1_p_reg, s1_i_reg;
    logic signed [PD_W-1:0]  s1_d_reg;
    logic                    s1_active_reg;
    logic [MAG_W-1:0]        s1_lim_reg;

    // Stage 2: scaled and saturated sum
    logic                    s2_valid_reg, s2_valid_next;
    logic signed [SIG_W-1:0] s2_speed_reg;
    logic                    s2_active_reg;
    logic [MAG_W-1:0]        s2_lim_reg;

    // Stage 3: output register
    logic                    out_valid_reg, out_valid_next;
    out_word_t               out_data_reg;

    logic                    out_adv, s2_adv, s1_adv;
    logic signed [PE_W-1:0]  prod_p, prod_i;
    logic signed [PD_W-1:0]  prod_d;
    logic signed [ACC_W-1:0] acc;
    logic signed [SH_W-1:0]  acc_sh;
    logic signed [SIG_W-1:0] acc_sat;
    logic signed [SIG_W:0]   spd33, lim33, md33, clamped;
    logic signed [SIG_W:0]   driven;

    assign out_adv = !out_valid_reg || !out_stall;
    assign s2_adv = !s2_valid_reg || out_adv;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign pop = !q_empty && s1_adv;

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_comb
    begin
        prod_p = $signed({1'b0, cfg.kp}) * pop_data.err;
        prod_i = $signed({1'b0, cfg.ki}) * pop_data.integral;
        prod_d = $signed({1'b0, cfg.kd}) * pop_data.deriv;

        // Floor divide by 256 is an arithmetic shift
        acc = ACC_W'(s1_p_reg) + ACC_W'(s1_i_reg) + ACC_W'(s1_d_reg);
        acc_sh = acc[ACC_W-1:8];
        if ((&acc_sh[SH_W-1:SIG_W-1]) || !(|acc_sh[SH_W-1:SIG_W-1]))
        begin
            acc_sat = acc_sh[SIG_W-1:0];
        end
        else
        begin
            acc_sat = acc_sh[SH_W-1] ? SIG_MIN : SIG_MAX;
        end

        spd33 = {s2_speed_reg[SIG_W-1], s2_speed_reg};
        lim33 = {2'b00, s2_lim_reg};
        md33 = {2'b00, cfg.min_drive};
        priority if (spd33 > lim33)
        begin
            clamped = lim33;
        end
        else if (spd33 < -lim33)
        begin
            clamped = -lim33;
        end
        else
        begin
            clamped = spd33;
        end
        priority if (clamped > 0 && clamped < md33)
        begin
            driven = md33;
        end
        else if (clamped < 0 && clamped > -md33)
        begin
            driven = -md33;
        end
        else
        begin
            driven = clamped;
        end

        s1_valid_next = s1_adv ? pop : s1_valid_reg;
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_adv ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_p_reg <= prod_p;
            s1_i_reg <= prod_i;
            s1_d_reg <= prod_d;
            s1_active_reg <= pop_data.active;
            s1_lim_reg <= pop_data.max_speed;
        end
        if (s2_adv)
        begin
            s2_speed_reg <= acc_sat;
            s2_active_reg <= s1_active_reg;
            s2_lim_reg <= s1_lim_reg;
        end
        if (out_adv)
        begin
            out_data_reg.speed <= s2_active_reg ? driven[SIG_W-1:0] : '0;
            out_data_reg.active <= s2_active_reg;
        end
    end

endmodule

// ===== hdl/pidsd_checker.sv =====
// Port-level checks on the output channel of the PID step block, with its bind.
module pidsd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input pidsd_pkg::out_word_t out_data
);
    import pidsd_pkg::*;

    // A stalled word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // A settled step drives zero
    a_settled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.active |-> out_data.speed == '0)
        else $error("settled word carries nonzero speed");

    // Both clamp limits are at most 31 bits, so the most negative code never shows
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.speed != SIG_MIN)
        else $error("speed outside symmetric clamp range");

endmodule

bind pid_step_with_settle_detect pidsd_checker u_pidsd_checker (.*);
